// ===== design/vas_pkg.sv =====
`timescale 1ns / 1ps

package vas_pkg;

  // slot table size and derived widths
  localparam int VOICE_SLOTS = 16;
  localparam int SLOT_W      = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
  localparam int COUNT_W     = $clog2(VOICE_SLOTS + 1);

  // fixed field widths
  localparam int KIND_W  = 2;
  localparam int NOTE_W  = 7;
  localparam int CHAN_W  = 4;
  localparam int VEL_W   = 7;
  localparam int IDX_W   = 4;
  localparam int MODE_W  = 2;
  localparam int AGE_W   = 32;
  localparam int OCNT_W  = 5;
  localparam int WIDE_W  = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_NOTE_ON  = 2'd0,
    KIND_NOTE_OFF = 2'd1,
    KIND_RELEASE  = 2'd2,
    KIND_TICK     = 2'd3
  } kind_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_OLDEST  = 2'd0,
    MODE_QUIETEST = 2'd1,
    MODE_HIGHEST = 2'd2,
    MODE_LOWEST  = 2'd3
  } mode_t;

  // command held for the whole scan
  typedef struct packed {
    kind_t              kind;
    logic [NOTE_W-1:0]  note;
    logic [CHAN_W-1:0]  channel;
    logic [IDX_W-1:0]   slot_index;
    mode_t              mode;
  } cmd_t;

  // running result handed from cell to cell
  typedef struct packed {
    logic               free_found;
    logic [SLOT_W-1:0]  free_idx;
    logic               match_found;
    logic [SLOT_W-1:0]  match_idx;
    logic               rel_hit;
    logic [SLOT_W-1:0]  rel_idx;
    logic               have_best;
    logic [SLOT_W-1:0]  best_idx;
    logic [AGE_W-1:0]   best_key;
    logic [COUNT_W-1:0] count;
  } carry_t;

  // table update broadcast at commit
  typedef struct packed {
    logic               set_en;
    logic [SLOT_W-1:0]  set_idx;
    logic [NOTE_W-1:0]  note;
    logic [CHAN_W-1:0]  channel;
    logic [VEL_W-1:0]   velocity;
    logic [AGE_W-1:0]   age;
    logic               clr_en;
    logic [SLOT_W-1:0]  clr_idx;
  } wr_t;

endpackage

// ===== design/vas_cell.sv =====
`timescale 1ns / 1ps

module vas_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [vas_pkg::SLOT_W-1:0] cell_idx,
  input  vas_pkg::cmd_t         cmd,
  input  vas_pkg::wr_t          wr,
  input  vas_pkg::carry_t       carry_in,
  output vas_pkg::carry_t       carry_out
);
  import vas_pkg::*;

  logic              active;
  logic [NOTE_W-1:0] note;
  logic [CHAN_W-1:0] channel;
  logic [VEL_W-1:0]  velocity;
  logic [AGE_W-1:0]  age;

  logic [AGE_W-1:0]  key;
  carry_t            carry_next;

  // slot state: active flag resets, payload is written on note on
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (wr.set_en && wr.set_idx == cell_idx) begin
      active <= 1'b1;
    end else if (wr.clr_en && wr.clr_idx == cell_idx) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set_en && wr.set_idx == cell_idx) begin
      note     <= wr.note;
      channel  <= wr.channel;
      velocity <= wr.velocity;
      age      <= wr.age;
    end
  end

  // victim key, smaller is a better victim
  always_comb begin
    unique case (cmd.mode)
      MODE_OLDEST:   key = age;
      MODE_QUIETEST: key = AGE_W'(velocity);
      MODE_HIGHEST:  key = AGE_W'(~note);
      MODE_LOWEST:   key = AGE_W'(note);
      default:       key = age;
    endcase
  end

  // fold this slot into the running result
  always_comb begin
    carry_next = carry_in;
    if (!carry_in.free_found && !active) begin
      carry_next.free_found = 1'b1;
      carry_next.free_idx   = cell_idx;
    end
    if (!carry_in.match_found && active && note == cmd.note && channel == cmd.channel) begin
      carry_next.match_found = 1'b1;
      carry_next.match_idx   = cell_idx;
    end
    if (active && WIDE_W'(cmd.slot_index) == WIDE_W'(cell_idx)) begin
      carry_next.rel_hit = 1'b1;
      carry_next.rel_idx = cell_idx;
    end
    if (!carry_in.have_best || key < carry_in.best_key) begin
      carry_next.have_best = 1'b1;
      carry_next.best_idx  = cell_idx;
      carry_next.best_key  = key;
    end
    carry_next.count = carry_in.count + COUNT_W'(active);
  end

  // hand the result to the next cell
  always_ff @(posedge clk) begin
    carry_out <= carry_next;
  end

endmodule

// ===== design/voice_allocator_with_stealing.sv =====
`timescale 1ns / 1ps

// Voice allocator with stealing. Each slot of the voice table lives in one
// cell of a chain; a command is latched on start and a running result (first
// free slot, first note-off match, release hit, best steal victim, active
// count) walks the chain one cell per clock. Once it leaves the last cell the
// table is updated and one result beat is shown on the outputs for exactly
// one cycle with done high. Busy is high while an item scans the chain and
// commits, and a new start is taken on the cycle done is shown. The receiver
// cannot stall the result beat. stealing_mode is written through
// cfg_valid/cfg_ready, ready whenever no item is in flight.
module voice_allocator_with_stealing (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [vas_pkg::KIND_W-1:0] kind,
  input  logic [vas_pkg::NOTE_W-1:0] note,
  input  logic [vas_pkg::CHAN_W-1:0] channel,
  input  logic [vas_pkg::VEL_W-1:0]  velocity,
  input  logic [vas_pkg::IDX_W-1:0]  slot_index,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [vas_pkg::MODE_W-1:0] stealing_mode,
  output logic                      done,
  output logic [vas_pkg::IDX_W-1:0]  voice_slot,
  output logic                      slot_valid,
  output logic                      was_stolen,
  output logic [vas_pkg::OCNT_W-1:0] active_count,
  output logic                      any_free
);
  import vas_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  state_t            state;
  logic [SLOT_W-1:0] cnt;
  mode_t             steal_mode;
  cmd_t              cmd;
  logic [VEL_W-1:0]  cmd_vel;
  logic [AGE_W-1:0]  age_counter;

  carry_t            carry [VOICE_SLOTS+1];
  carry_t            fin;
  wr_t               wr;

  logic [COUNT_W-1:0] count_next;
  logic [IDX_W-1:0]   slot_next;
  logic               valid_next;
  logic               stolen_next;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      steal_mode <= MODE_OLDEST;
    end else if (cfg_valid && cfg_ready) begin
      steal_mode <= mode_t'(stealing_mode);
    end
  end

  // latch the command beat
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd.kind       <= kind_t'(kind);
      cmd.note       <= note;
      cmd.channel    <= channel;
      cmd.slot_index <= slot_index;
      cmd.mode       <= (cfg_valid && cfg_ready) ? mode_t'(stealing_mode) : steal_mode;
      cmd_vel        <= velocity;
    end
  end

  // chain of slot cells
  assign carry[0] = '0;

  for (genvar i = 0; i < VOICE_SLOTS; i++) begin : g_cell
    vas_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (SLOT_W'(i)),
      .cmd       (cmd),
      .wr        (wr),
      .carry_in  (carry[i]),
      .carry_out (carry[i+1])
    );
  end

  assign fin = carry[VOICE_SLOTS];

  // decision at commit
  always_comb begin
    wr          = '0;
    count_next  = fin.count;
    slot_next   = '0;
    valid_next  = 1'b0;
    stolen_next = 1'b0;
    wr.note     = cmd.note;
    wr.channel  = cmd.channel;
    wr.velocity = cmd_vel;
    wr.age      = age_counter;
    unique case (cmd.kind)
      KIND_NOTE_ON: begin
        wr.set_en   = (state == ST_COMMIT);
        wr.set_idx  = fin.free_found ? fin.free_idx : fin.best_idx;
        slot_next   = IDX_W'(wr.set_idx);
        valid_next  = 1'b1;
        stolen_next = !fin.free_found;
        if (fin.free_found) begin
          count_next = fin.count + COUNT_W'(1);
        end
      end
      KIND_NOTE_OFF: begin
        wr.clr_en  = (state == ST_COMMIT) && fin.match_found;
        wr.clr_idx = fin.match_idx;
        if (fin.match_found) begin
          slot_next  = IDX_W'(fin.match_idx);
          valid_next = 1'b1;
          count_next = fin.count - COUNT_W'(1);
        end
      end
      KIND_RELEASE: begin
        wr.clr_en  = (state == ST_COMMIT) && fin.rel_hit;
        wr.clr_idx = fin.rel_idx;
        slot_next  = cmd.slot_index;
        valid_next = fin.rel_hit;
        if (fin.rel_hit) begin
          count_next = fin.count - COUNT_W'(1);
        end
      end
      KIND_TICK: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer, age counter and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      age_counter <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SCAN;
            cnt   <= '0;
          end
        end
        ST_SCAN: begin
          if (cnt == SLOT_W'(VOICE_SLOTS - 1)) begin
            state <= ST_COMMIT;
          end else begin
            cnt <= cnt + SLOT_W'(1);
          end
        end
        ST_COMMIT: begin
          state        <= ST_IDLE;
          done         <= 1'b1;
          voice_slot   <= slot_next;
          slot_valid   <= valid_next;
          was_stolen   <= stolen_next;
          active_count <= OCNT_W'(count_next);
          any_free     <= (count_next < COUNT_W'(VOICE_SLOTS));
          if (cmd.kind == KIND_TICK && age_counter != AGE_MAX) begin
            age_counter <= age_counter + AGE_W'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a started item keeps the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // the result beat never overlaps a scan
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while scan in flight");

  // a steal only happens with a full table and leaves it full
  a_steal_full: assert property (@(posedge clk) disable iff (rst)
    done && was_stolen |-> slot_valid && !any_free
      && active_count == OCNT_W'(VOICE_SLOTS))
    else $error("steal reported with free slots");

  // count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> active_count <= OCNT_W'(VOICE_SLOTS))
    else $error("active count beyond slot total");

endmodule
